// ----- rtl/ist_pkg.sv -----
// Package for the insert statement tokenizer.
// Holds the result and state types, the result kind and status codes,
// and the keyword character tables. No dependencies.
package ist_pkg;

   localparam logic [2:0] KIND_TABLE_CHAR = 3'd0;
   localparam logic [2:0] KIND_TABLE_END  = 3'd1;
   localparam logic [2:0] KIND_COL_CHAR   = 3'd2;
   localparam logic [2:0] KIND_COL_END    = 3'd3;
   localparam logic [2:0] KIND_VAL_CHAR   = 3'd4;
   localparam logic [2:0] KIND_VAL_END    = 3'd5;
   localparam logic [2:0] KIND_STATUS     = 3'd6;

   localparam logic [1:0] ST_SUCCESS  = 2'd0;
   localparam logic [1:0] ST_SYNTAX   = 2'd1;
   localparam logic [1:0] ST_UNKNOWN  = 2'd2;
   localparam logic [1:0] ST_NO_KEYWD = 2'd3;

   localparam logic [1:0] PFX_NONE   = 2'd0;
   localparam logic [1:0] PFX_INSERT = 2'd1;
   localparam logic [1:0] PFX_SELECT = 2'd2;

   localparam logic [3:0] INSERT_LEN  = 4'd12;
   localparam logic [3:0] SELECT_LEN  = 4'd7;
   localparam logic [3:0] KEYWORD_LEN = 4'd6;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LOW_I  = 8'h69;
   localparam logic [7:0] CH_LOW_S  = 8'h73;

   typedef enum logic [7:0] {
      PH_PREFIX  = 8'b0000_0001,
      PH_TABLE   = 8'b0000_0010,
      PH_COLSEEK = 8'b0000_0100,
      PH_COLS    = 8'b0000_1000,
      PH_KEYWORD = 8'b0001_0000,
      PH_VALSEEK = 8'b0010_0000,
      PH_VALS    = 8'b0100_0000,
      PH_DONE    = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] match_pos;
      logic [1:0] prefix_kind;
      logic       reported;
   } state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch_out;
      logic [1:0] status;
      logic       is_select;
      logic       last;
   } result_type;

   // Positions past the end of a word give NUL, which never matches a live character.
   function automatic logic [7:0] insert_char(input logic [3:0] idx);
      case (idx)
         4'd0:    insert_char = 8'h69; // i
         4'd1:    insert_char = 8'h6E; // n
         4'd2:    insert_char = 8'h73; // s
         4'd3:    insert_char = 8'h65; // e
         4'd4:    insert_char = 8'h72; // r
         4'd5:    insert_char = 8'h74; // t
         4'd6:    insert_char = 8'h20;
         4'd7:    insert_char = 8'h69; // i
         4'd8:    insert_char = 8'h6E; // n
         4'd9:    insert_char = 8'h74; // t
         4'd10:   insert_char = 8'h6F; // o
         4'd11:   insert_char = 8'h20;
         default: insert_char = CH_NUL;
      endcase
   endfunction

   function automatic logic [7:0] select_char(input logic [3:0] idx);
      case (idx)
         4'd0:    select_char = 8'h73; // s
         4'd1:    select_char = 8'h65; // e
         4'd2:    select_char = 8'h6C; // l
         4'd3:    select_char = 8'h65; // e
         4'd4:    select_char = 8'h63; // c
         4'd5:    select_char = 8'h74; // t
         4'd6:    select_char = 8'h20;
         default: select_char = CH_NUL;
      endcase
   endfunction

   function automatic logic [7:0] keyword_char(input logic [3:0] idx);
      case (idx)
         4'd0:    keyword_char = 8'h76; // v
         4'd1:    keyword_char = 8'h61; // a
         4'd2:    keyword_char = 8'h6C; // l
         4'd3:    keyword_char = 8'h75; // u
         4'd4:    keyword_char = 8'h65; // e
         4'd5:    keyword_char = 8'h73; // s
         default: keyword_char = CH_NUL;
      endcase
   endfunction

endpackage

// ----- rtl/ist_step.sv -----
// Per-character step of the tokenizer: next parser state and up to two results.
// Purely combinational. Depends on ist_pkg.
module ist_step
   import ist_pkg::*;
(
   input  state_type  cur_st,
   input  logic [7:0] ch,
   output state_type  nxt_st,
   output result_type res0,
   output result_type res1,
   output logic [1:0] res_cnt
);

   state_type  rst_st;
   logic [3:0] mp_inc;

   assign rst_st = '{phase: PH_PREFIX, match_pos: 4'd0, prefix_kind: PFX_NONE, reported: 1'b0};
   assign mp_inc = 4'(cur_st.match_pos + 4'd1);

   always_comb begin
      nxt_st  = cur_st;
      res0    = '0;
      res1    = '0;
      res_cnt = 2'd0;

      if (ch == CH_NUL) begin
         if (!cur_st.reported) begin
            res0.kind = KIND_STATUS;
            res_cnt   = 2'd1;
            if (cur_st.phase == PH_PREFIX) begin
               res0.status = ST_UNKNOWN;
            end else if (cur_st.phase == PH_KEYWORD && cur_st.match_pos != 4'd0) begin
               res0.status = ST_NO_KEYWD;
            end else begin
               res0.status = ST_SYNTAX;
            end
         end
         nxt_st = rst_st;
      end else begin
         case (cur_st.phase)
            PH_PREFIX: begin
               if (cur_st.match_pos == 4'd0) begin
                  if (ch == CH_LOW_I) begin
                     nxt_st.prefix_kind = PFX_INSERT;
                     nxt_st.match_pos   = 4'd1;
                  end else if (ch == CH_LOW_S) begin
                     nxt_st.prefix_kind = PFX_SELECT;
                     nxt_st.match_pos   = 4'd1;
                  end else begin
                     res0.kind = KIND_STATUS;
                     res0.status = ST_UNKNOWN;
                     res_cnt = 2'd1;
                     nxt_st.phase = PH_DONE;
                     nxt_st.reported = 1'b1;
                  end
               end else if (cur_st.prefix_kind == PFX_INSERT) begin
                  if (insert_char(cur_st.match_pos) != ch) begin
                     res0.kind = KIND_STATUS;
                     res0.status = ST_UNKNOWN;
                     res_cnt = 2'd1;
                     nxt_st.phase = PH_DONE;
                     nxt_st.reported = 1'b1;
                  end else if (mp_inc == INSERT_LEN) begin
                     nxt_st.phase = PH_TABLE;
                     nxt_st.match_pos = 4'd0;
                  end else begin
                     nxt_st.match_pos = mp_inc;
                  end
               end else begin
                  res0.kind = KIND_STATUS;
                  res_cnt = 2'd1;
                  if (select_char(cur_st.match_pos) != ch) begin
                     res0.status = ST_UNKNOWN;
                     nxt_st.phase = PH_DONE;
                     nxt_st.reported = 1'b1;
                  end else if (mp_inc == SELECT_LEN) begin
                     res0.is_select = 1'b1;
                     nxt_st.match_pos = 4'd0;
                     nxt_st.phase = PH_DONE;
                     nxt_st.reported = 1'b1;
                  end else begin
                     res_cnt = 2'd0;
                     nxt_st.match_pos = mp_inc;
                  end
               end
            end
            PH_TABLE: begin
               res_cnt = 2'd1;
               if (ch == CH_SPACE) begin
                  res0.kind = KIND_TABLE_END;
                  nxt_st.phase = PH_COLSEEK;
               end else begin
                  res0.kind = KIND_TABLE_CHAR;
                  res0.ch_out = ch;
               end
            end
            PH_COLSEEK: begin
               if (ch == CH_OPEN) begin
                  nxt_st.phase = PH_COLS;
               end
            end
            PH_COLS: begin
               if (ch == CH_CLOSE) begin
                  res0.kind = KIND_COL_END;
                  res_cnt = 2'd1;
                  nxt_st.phase = PH_KEYWORD;
                  nxt_st.match_pos = 4'd0;
               end else if (ch == CH_COMMA) begin
                  res0.kind = KIND_COL_END;
                  res_cnt = 2'd1;
               end else if (ch != CH_SPACE) begin
                  res0.kind = KIND_COL_CHAR;
                  res0.ch_out = ch;
                  res_cnt = 2'd1;
               end
            end
            PH_KEYWORD: begin
               if (!(cur_st.match_pos == 4'd0 && ch == CH_SPACE)) begin
                  if (keyword_char(cur_st.match_pos) != ch) begin
                     res0.kind = KIND_STATUS;
                     res0.status = ST_NO_KEYWD;
                     res_cnt = 2'd1;
                     nxt_st.phase = PH_DONE;
                     nxt_st.reported = 1'b1;
                  end else if (mp_inc == KEYWORD_LEN) begin
                     nxt_st.match_pos = 4'd0;
                     nxt_st.phase = PH_VALSEEK;
                  end else begin
                     nxt_st.match_pos = mp_inc;
                  end
               end
            end
            PH_VALSEEK: begin
               if (ch == CH_OPEN) begin
                  nxt_st.phase = PH_VALS;
               end
            end
            PH_VALS: begin
               if (ch == CH_CLOSE) begin
                  res0.kind = KIND_VAL_END;
                  res1.kind = KIND_STATUS;
                  res1.status = ST_SUCCESS;
                  res_cnt = 2'd2;
                  nxt_st.phase = PH_DONE;
                  nxt_st.reported = 1'b1;
               end else if (ch == CH_COMMA) begin
                  res0.kind = KIND_VAL_END;
                  res_cnt = 2'd1;
               end else if (ch != CH_SPACE) begin
                  res0.kind = KIND_VAL_CHAR;
                  res0.ch_out = ch;
                  res_cnt = 2'd1;
               end
            end
            default: begin
            end
         endcase
      end

      res0.last = (res_cnt == 2'd1);
      res1.last = 1'b1;
   end

endmodule

// ----- rtl/insert_statement_tokenizer.sv -----
// Insert statement tokenizer, top level: input register, parser step, result queue.
// An accepted character passes the input register and the result queue before its first result is offered.
// Throughput: one character per cycle while the queue has room for two results; a
// character with two results offers them in turn through the single result port of a 4-entry queue.
// Reset (synchronous, active high) empties the pipeline and returns the parser
// to prefix matching. Depends on ist_pkg and ist_step.
module insert_statement_tokenizer
   import ist_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_ch_out,
   output logic [1:0] rsp_status,
   output logic       rsp_is_select,
   output logic       rsp_last
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_ch_ff;
   state_type  st_ff, st_in;
   result_type res0, res1, head;
   logic [1:0] res_cnt;
   logic       proc, pop;
   logic [2:0] push_n;

   result_type q_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;

   ist_step u_step (
      .cur_st (st_ff),
      .ch     (in_ch_ff),
      .nxt_st (st_in),
      .res0   (res0),
      .res1   (res1),
      .res_cnt(res_cnt)
   );

   // an item is stepped only when the queue has room for two results
   assign proc      = in_vld_ff && (cnt_ff <= 3'd2);
   assign req_ready = !in_vld_ff || proc;
   assign in_vld_in = req_valid || (in_vld_ff && !proc);

   assign pop       = rsp_valid && rsp_ready;
   assign push_n    = proc ? {1'b0, res_cnt} : 3'd0;
   assign cnt_in    = 3'(cnt_ff + push_n - {2'b00, pop});
   assign wr_ptr_in = 2'(wr_ptr_ff + push_n[1:0]);
   assign rd_ptr_in = 2'(rd_ptr_ff + {1'b0, pop});

   assign head          = q_ff[rd_ptr_ff];
   assign rsp_valid     = (cnt_ff != 3'd0);
   assign rsp_kind      = head.kind;
   assign rsp_ch_out    = head.ch_out;
   assign rsp_status    = head.status;
   assign rsp_is_select = head.is_select;
   assign rsp_last      = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         st_ff     <= '{phase: PH_PREFIX, match_pos: 4'd0, prefix_kind: PFX_NONE,
                        reported: 1'b0};
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         cnt_ff    <= 3'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (proc) begin
            st_ff <= st_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_ch_ff <= req_ch;
      end
      if (proc && res_cnt != 2'd0) begin
         q_ff[wr_ptr_ff] <= res0;
      end
      if (proc && res_cnt == 2'd2) begin
         q_ff[2'(wr_ptr_ff + 2'd1)] <= res1;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result queue overfilled");

   a_pair_queued: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> cnt_ff >= 3'd2)
      else $error("non-last result offered without its partner queued");

   a_pair_push: assert property (@(posedge clock) disable iff (reset)
      proc && res_cnt == 2'd2 && !pop |=> cnt_ff == 3'($past(cnt_ff) + 3'd2))
      else $error("two-result item not fully queued");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_STATUS |-> rsp_status == ST_SUCCESS && !rsp_is_select)
      else $error("status fields set on a token result");

endmodule

// ----- dv/insert_statement_tokenizer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for insert_statement_tokenizer: directed and random statements,
// with random idling on both channels, checked against a built-in token predictor.
// Depends on ist_pkg and the insert_statement_tokenizer RTL.
module insert_statement_tokenizer_tb;
   import ist_pkg::*;

   localparam int CHAR_TARGET = 1050;
   localparam int CYCLE_LIMIT = 200000;

   class token_scoreboard;
      typedef enum logic [2:0] {
         SCAN_PREFIX, SCAN_TABLE, SCAN_COLSEEK, SCAN_COLS,
         SCAN_KEYWORD, SCAN_VALSEEK, SCAN_VALS, SCAN_DONE
      } scan_type;

      scan_type   scan;
      logic [3:0] pos;
      logic [1:0] pfx;
      bit         said;
      string      insert_word = "insert into ";
      string      select_word = "select ";
      string      keyword     = "values";
      result_type batch[$];
      result_type expected_tokens[$];
      int         errors;
      int         checked;
      int         status_tally[4];
      int         select_hits;

      function new();
         restart();
      endfunction

      function void restart();
         scan = SCAN_PREFIX;
         pos  = 4'd0;
         pfx  = PFX_NONE;
         said = 1'b0;
      endfunction

      function void add(logic [2:0] kind, logic [7:0] c, logic [1:0] st, logic sel);
         result_type r;
         r.kind      = kind;
         r.ch_out    = c;
         r.status    = st;
         r.is_select = sel;
         r.last      = 1'b0;
         batch.push_back(r);
      endfunction

      function void give_status(logic [1:0] st, logic sel);
         said = 1'b1;
         scan = SCAN_DONE;
         add(KIND_STATUS, CH_NUL, st, sel);
         status_tally[st]++;
         if (sel) select_hits++;
      endfunction

      function void list_char(logic [7:0] c, logic [2:0] char_kind, logic [2:0] end_kind);
         if (c == CH_COMMA) add(end_kind, CH_NUL, ST_SUCCESS, 1'b0);
         else if (c != CH_SPACE) add(char_kind, c, ST_SUCCESS, 1'b0);
      endfunction

      function void predict_char(logic [7:0] c);
         batch.delete();
         if (c == CH_NUL) begin
            if (!said) begin
               if (scan == SCAN_PREFIX) give_status(ST_UNKNOWN, 1'b0);
               else if (scan == SCAN_KEYWORD && pos != 4'd0) give_status(ST_NO_KEYWD, 1'b0);
               else give_status(ST_SYNTAX, 1'b0);
            end
            restart();
         end else begin
            case (scan)
               SCAN_PREFIX: begin
                  if (pos == 4'd0) begin
                     if (c == CH_LOW_I) begin
                        pfx = PFX_INSERT;
                        pos = 4'd1;
                     end else if (c == CH_LOW_S) begin
                        pfx = PFX_SELECT;
                        pos = 4'd1;
                     end else begin
                        give_status(ST_UNKNOWN, 1'b0);
                     end
                  end else if (pfx == PFX_INSERT) begin
                     if (c != 8'(insert_word[pos])) begin
                        give_status(ST_UNKNOWN, 1'b0);
                     end else begin
                        pos++;
                        if (pos == 4'(insert_word.len())) begin
                           scan = SCAN_TABLE;
                           pos  = 4'd0;
                        end
                     end
                  end else begin
                     if (c != 8'(select_word[pos])) begin
                        give_status(ST_UNKNOWN, 1'b0);
                     end else begin
                        pos++;
                        if (pos == 4'(select_word.len())) begin
                           pos = 4'd0;
                           give_status(ST_SUCCESS, 1'b1);
                        end
                     end
                  end
               end
               SCAN_TABLE: begin
                  if (c == CH_SPACE) begin
                     add(KIND_TABLE_END, CH_NUL, ST_SUCCESS, 1'b0);
                     scan = SCAN_COLSEEK;
                  end else begin
                     add(KIND_TABLE_CHAR, c, ST_SUCCESS, 1'b0);
                  end
               end
               SCAN_COLSEEK: if (c == CH_OPEN) scan = SCAN_COLS;
               SCAN_COLS: begin
                  if (c == CH_CLOSE) begin
                     add(KIND_COL_END, CH_NUL, ST_SUCCESS, 1'b0);
                     scan = SCAN_KEYWORD;
                     pos  = 4'd0;
                  end else begin
                     list_char(c, KIND_COL_CHAR, KIND_COL_END);
                  end
               end
               SCAN_KEYWORD: begin
                  if (!(pos == 4'd0 && c == CH_SPACE)) begin
                     if (c != 8'(keyword[pos])) begin
                        give_status(ST_NO_KEYWD, 1'b0);
                     end else begin
                        pos++;
                        if (pos == 4'(keyword.len())) begin
                           pos  = 4'd0;
                           scan = SCAN_VALSEEK;
                        end
                     end
                  end
               end
               SCAN_VALSEEK: if (c == CH_OPEN) scan = SCAN_VALS;
               SCAN_VALS: begin
                  if (c == CH_CLOSE) begin
                     add(KIND_VAL_END, CH_NUL, ST_SUCCESS, 1'b0);
                     give_status(ST_SUCCESS, 1'b0);
                  end else begin
                     list_char(c, KIND_VAL_CHAR, KIND_VAL_END);
                  end
               end
               default: ;
            endcase
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) expected_tokens.push_back(batch[i]);
      endfunction

      function int outstanding();
         return expected_tokens.size();
      endfunction

      function void check_result(logic [2:0] kind, logic [7:0] c, logic [1:0] st,
                                 logic sel, logic last);
         result_type want;
         if (expected_tokens.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: kind=%0d ch=%02h status=%0d sel=%0b last=%0b",
                        kind, c, st, sel, last);
            return;
         end
         want = expected_tokens.pop_front();
         checked++;
         if (want.kind !== kind || want.ch_out !== c || want.status !== st ||
             want.is_select !== sel || want.last !== last) begin
            errors++;
            if (errors <= 10) begin
               $display("result %0d: expected kind=%0d ch=%02h status=%0d sel=%0b last=%0b",
                        checked, want.kind, want.ch_out, want.status, want.is_select,
                        want.last);
               $display("   got kind=%0d ch=%02h status=%0d sel=%0b last=%0b",
                        kind, c, st, sel, last);
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_ch_out;
   logic [1:0] rsp_status;
   logic       rsp_is_select;
   logic       rsp_last;

   token_scoreboard sb = new();
   logic [7:0]      line_q[$];
   bit              calm = 1'b0;
   int              chars_sent = 0;
   int              statements = 0;
   int              cycles = 0;

   insert_statement_tokenizer i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_ch_out    (rsp_ch_out),
      .rsp_status    (rsp_status),
      .rsp_is_select (rsp_is_select),
      .rsp_last      (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_kind, rsp_ch_out, rsp_status, rsp_is_select, rsp_last);
         rsp_ready <= calm || ($urandom_range(0, 99) >= 9);
      end
   end

   task automatic send_char(input logic [7:0] c);
      if (!calm && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.predict_char(c);
      chars_sent++;
   endtask

   task automatic send_statement();
      foreach (line_q[i]) send_char(line_q[i]);
      send_char(CH_NUL);
      statements++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_char(input logic [7:0] avoid);
      logic [7:0] c;
      int         r;
      do begin
         r = $urandom_range(0, 99);
         if (r < 50) c = 8'h61 + 8'($urandom_range(0, 25));
         else if (r < 62) c = 8'h30 + 8'($urandom_range(0, 9));
         else if (r < 75) c = CH_COMMA;
         else if (r < 85) c = CH_SPACE;
         else c = 8'($urandom_range(1, 255));
      end while (c == avoid || c == CH_NUL);
      return c;
   endfunction

   function automatic void put_word(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(8'(s[i]));
   endfunction

   function automatic void put_run(input int n, input logic [7:0] avoid);
      repeat (n) line_q.push_back(pick_char(avoid));
   endfunction

   // broken variants: cut short or one character overwritten
   function automatic void damage();
      int n;
      if (line_q.size() == 0) return;
      if ($urandom_range(0, 1) == 0) begin
         n = $urandom_range(0, line_q.size() - 1);
         while (line_q.size() > n) void'(line_q.pop_back());
      end else begin
         line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(1, 255));
      end
   endfunction

   function automatic void build_statement();
      int r;
      r = $urandom_range(0, 99);
      line_q.delete();
      if (r < 75) begin
         put_word("insert into ");
         put_run($urandom_range(0, 4), CH_SPACE);
         line_q.push_back(CH_SPACE);
         put_run($urandom_range(0, 2), CH_OPEN);
         line_q.push_back(CH_OPEN);
         put_run($urandom_range(0, 5), CH_CLOSE);
         line_q.push_back(CH_CLOSE);
         repeat ($urandom_range(0, 2)) line_q.push_back(CH_SPACE);
         put_word("values");
         put_run($urandom_range(0, 2), CH_OPEN);
         line_q.push_back(CH_OPEN);
         put_run($urandom_range(0, 5), CH_CLOSE);
         line_q.push_back(CH_CLOSE);
         put_run($urandom_range(0, 3), CH_NUL);
         if (r >= 55) damage();
      end else if (r < 88) begin
         put_word("select ");
         put_run($urandom_range(0, 4), CH_NUL);
         if (r >= 84) damage();
      end else begin
         if ($urandom_range(0, 1) == 0)
            line_q.push_back($urandom_range(0, 1) ? CH_LOW_I : CH_LOW_S);
         repeat ($urandom_range(0, 6)) line_q.push_back(8'($urandom_range(1, 255)));
      end
   endfunction

   initial begin
      bit   paused;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty statement, top-bit byte, select with ignored tail, insert with empty table name
      line_q.delete();
      send_statement();
      line_q.delete();
      line_q.push_back(8'hFF);
      send_statement();
      line_q.delete();
      put_word("select x");
      send_statement();
      line_q.delete();
      put_word("insert into  (a, b,)values(x,1)");
      send_statement();
      drain();

      while (chars_sent < CHAR_TARGET) begin
         calm = (chars_sent > 500 && chars_sent < 700);
         build_statement();
         send_statement();
         if (!paused && chars_sent > 300) begin
            drain();
            paused = 1'b1;
         end
      end
      calm = 1'b0;
      drain();
      repeat (8) @(posedge clock);

      $display("%0d statements, %0d characters; %0d results checked", statements,
               chars_sent, sb.checked);
      $display("status: %0d success (%0d select), %0d syntax, %0d unknown, %0d no keyword",
               sb.status_tally[ST_SUCCESS], sb.select_hits, sb.status_tally[ST_SYNTAX],
               sb.status_tally[ST_UNKNOWN], sb.status_tally[ST_NO_KEYWD]);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d errors", sb.errors);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- insert_statement_tokenizer.f -----
rtl/ist_pkg.sv
rtl/ist_step.sv
rtl/insert_statement_tokenizer.sv
dv/insert_statement_tokenizer_tb.sv
